// ===== sv/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and idle during reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tlbat_pkg.sv =====
// ============================================================================
// TLB address translator package
// Widths, entry and control types, and the state encoding of the translator.
// ============================================================================
package tlbat_pkg;

    localparam int VA_W        = 16;
    localparam int PAGE_BITS   = 8;
    localparam int OFFSET_BITS = 8;
    localparam int TLB_DEPTH   = 16;
    localparam int FRAME_W     = 8;
    localparam int TAG_W       = 8;
    localparam int FREE_W      = 9;
    localparam int NUM_PAGES   = 1 << PAGE_BITS;

    typedef logic [PAGE_BITS-1:0]   t_page;
    typedef logic [OFFSET_BITS-1:0] t_offset;
    typedef logic [FRAME_W-1:0]     t_frame;
    typedef logic [TAG_W-1:0]       t_tag;

    // One TLB entry as held by a cell.
    typedef struct packed {
        logic   valid;
        t_tag   tag;
        t_frame frame;
    } t_tlb_entry;

    // Lookup result rippling from the oldest cell toward the newest.
    typedef struct packed {
        logic   hit;
        t_frame frame;
    } t_tlb_carry;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic   update;
        logic   hit;
        logic   full;
        t_tag   tag;
        t_frame frame;
    } t_tlb_ctrl;

    // Page table read request or allocation request.
    typedef struct packed {
        logic  en;
        t_page page;
    } t_pt_req;

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

endpackage

// ===== sv/tlbat_cell.sv =====
// ============================================================================
// TLB cell
// One LRU-ordered TLB entry: compares its tag, passes the lookup result on,
// and on update either takes its newer neighbor's entry or the new entry.
// ============================================================================
module tlbat_cell
    import tlbat_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tlb_ctrl  i_ctrl,
    input  t_tag       i_look_tag,
    input  t_tlb_carry i_carry,
    output t_tlb_carry o_carry,
    input  logic       i_prev_valid,
    input  t_tlb_entry i_next,
    output t_tlb_entry o_entry
);

    logic       r_valid;
    t_tag       r_tag;
    t_frame     r_frame;
    logic       match;
    logic       is_tail;
    logic       is_free_head;
    logic       do_shift;
    logic       do_load;

    assign match        = r_valid && (r_tag == i_look_tag);
    assign is_tail      = r_valid && !i_next.valid;
    assign is_free_head = !r_valid && i_prev_valid;

    assign o_carry.hit   = i_carry.hit || match;
    assign o_carry.frame = match ? r_frame : i_carry.frame;

    // Entries behind a hit, or all entries on a miss into a full TLB, move one
    // place toward the oldest end; the tail (or first free cell) takes the new entry.
    assign do_shift = i_ctrl.update && !is_tail
                      && ((i_ctrl.hit && o_carry.hit) || (!i_ctrl.hit && i_ctrl.full));
    assign do_load  = i_ctrl.update
                      && ((i_ctrl.hit || i_ctrl.full) ? is_tail : is_free_head);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (do_load) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_tag   <= i_ctrl.tag;
            r_frame <= i_ctrl.frame;
        end else if (do_shift) begin
            r_tag   <= i_next.tag;
            r_frame <= i_next.frame;
        end
    end

    assign o_entry.valid = r_valid;
    assign o_entry.tag   = r_tag;
    assign o_entry.frame = r_frame;

endmodule

// ===== sv/tlbat_page_table.sv =====
// ============================================================================
// Page table
// Frame map memory with registered read, presence bits and the frame allocator.
// ============================================================================
module tlbat_page_table
    import tlbat_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_pt_req i_rd,
    output logic    o_present,
    output t_frame  o_frame,
    input  t_pt_req i_alloc,
    output t_frame  o_free_frame
);

    t_frame                r_map [NUM_PAGES];
    logic [NUM_PAGES-1:0]  r_present;
    logic [FREE_W-1:0]     r_next_free;
    logic                  r_present_q;
    t_frame                r_frame_q;

    assign o_free_frame = r_next_free[FRAME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_alloc.en) begin
            r_map[i_alloc.page] <= o_free_frame;
        end
        if (i_rd.en) begin
            r_frame_q <= r_map[i_rd.page];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_next_free <= '0;
            r_present_q <= 1'b0;
        end else begin
            if (i_alloc.en) begin
                r_present[i_alloc.page] <= 1'b1;
                r_next_free             <= r_next_free + FREE_W'(1);
            end
            if (i_rd.en) begin
                r_present_q <= r_present[i_rd.page];
            end
        end
    end

    assign o_present = r_present_q;
    assign o_frame   = r_frame_q;

endmodule

// ===== sv/tlb_lru_address_translator.sv =====
// ============================================================================
// TLB LRU address translator
// Translates a virtual address through an LRU-ordered TLB and a demand-paged
// page table, allocating frames in order on a page fault.
// ============================================================================
//
//  Channel | Direction | Handshake                  | Beat payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | into      | i_in_valid / o_in_stall    | i_virtual_address
//  out     | out of    | o_out_valid / i_out_stall  | o_physical_address, o_frame_number,
//          |           |                            | o_tlb_hit, o_page_fault, o_fetch_page
//
// For each beat, the accept cycle launches the page table memory read while the
// address is registered, and the S_LOOK state resolves the TLB chain,
// commits the LRU update and page allocation, and loads the output register.
// The next input beat is taken right after, even while the result still waits.
// A stalled output register holds the block in S_LOOK until it drains.
// Reset is synchronous and active low; it empties the TLB, clears all page
// presence bits and restarts frame allocation at frame zero.
//
// The TLB is a row of cells, oldest entry at cell 0. The lookup result ripples
// from cell 0 upward. On update the hit cell and those above it, or all cells on a
// full miss, shift down; the tail or first free cell takes the entry just used.
module tlb_lru_address_translator
    import tlbat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [VA_W-1:0]   i_virtual_address,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VA_W-1:0]   o_physical_address,
    output logic [FRAME_W-1:0] o_frame_number,
    output logic              o_tlb_hit,
    output logic              o_page_fault,
    output logic [TAG_W-1:0]  o_fetch_page
);

`include "assert_macros.svh"

    t_state            r_state;
    t_state            n_state;
    logic [VA_W-1:0]   r_va;
    logic              accept_in;
    logic              commit;

    // Output register.
    logic              r_out_valid;
    logic [VA_W-1:0]   r_phys;
    t_frame            r_frame;
    logic              r_hit;
    logic              r_fault;
    t_tag              r_fetch;

    // Lookup of the held address.
    t_page             look_page;
    t_offset           look_offset;
    t_tag              look_tag;
    logic              hit;
    logic              fault;
    t_frame            frame;

    // Page table interface.
    t_pt_req           pt_rd;
    t_pt_req           pt_alloc;
    logic              pt_present;
    t_frame            pt_frame;
    t_frame            free_frame;

    // TLB chain.
    t_tlb_ctrl         tlb_ctrl;
    t_tlb_entry        tlb_ent   [TLB_DEPTH];
    t_tlb_carry        tlb_carry [TLB_DEPTH+1];
    logic [TLB_DEPTH-1:0] tlb_valid;

    // ------------------------------------------------------------------
    // Control: one beat in flight; the S_LOOK state waits for room in the
    // output register before committing anything.
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state == S_LOOK);
    assign accept_in  = i_in_valid && !o_in_stall;
    assign commit     = (r_state == S_LOOK) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_va <= i_virtual_address;
        end
    end

    // ------------------------------------------------------------------
    // Page table: read at accept, allocate at commit on a fault.
    // ------------------------------------------------------------------
    assign pt_rd.en   = accept_in;
    assign pt_rd.page = i_virtual_address[OFFSET_BITS +: PAGE_BITS];

    assign look_page   = r_va[OFFSET_BITS +: PAGE_BITS];
    assign look_offset = r_va[OFFSET_BITS-1:0];
    assign look_tag    = TAG_W'(look_page);

    tlbat_page_table u_page_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd         (pt_rd),
        .o_present    (pt_present),
        .o_frame      (pt_frame),
        .i_alloc      (pt_alloc),
        .o_free_frame (free_frame)
    );

    // ------------------------------------------------------------------
    // TLB cell row. The newest neighbor of the last cell is an empty slot,
    // and the cell before cell 0 counts as occupied.
    // ------------------------------------------------------------------
    assign tlb_carry[0].hit   = 1'b0;
    assign tlb_carry[0].frame = '0;

    for (genvar k = 0; k < TLB_DEPTH; k++) begin : g_cell
        t_tlb_entry next_ent;
        logic       prev_valid;

        if (k == TLB_DEPTH - 1) begin : g_last
            assign next_ent = '0;
        end else begin : g_mid
            assign next_ent = tlb_ent[k+1];
        end

        if (k == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = tlb_ent[k-1].valid;
        end

        tlbat_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (tlb_ctrl),
            .i_look_tag   (look_tag),
            .i_carry      (tlb_carry[k]),
            .o_carry      (tlb_carry[k+1]),
            .i_prev_valid (prev_valid),
            .i_next       (next_ent),
            .o_entry      (tlb_ent[k])
        );

        assign tlb_valid[k] = tlb_ent[k].valid;
    end

    // ------------------------------------------------------------------
    // Resolution: TLB first, then the page table, else a fresh frame.
    // ------------------------------------------------------------------
    assign hit   = tlb_carry[TLB_DEPTH].hit;
    assign fault = !hit && !pt_present;

    always_comb begin
        priority if (hit) begin
            frame = tlb_carry[TLB_DEPTH].frame;
        end else if (pt_present) begin
            frame = pt_frame;
        end else begin
            frame = free_frame;
        end
    end

    assign tlb_ctrl.update = commit;
    assign tlb_ctrl.hit    = hit;
    assign tlb_ctrl.full   = tlb_ent[TLB_DEPTH-1].valid;
    assign tlb_ctrl.tag    = look_tag;
    assign tlb_ctrl.frame  = frame;

    assign pt_alloc.en   = commit && fault;
    assign pt_alloc.page = look_page;

    // ------------------------------------------------------------------
    // Output register: takes a result while empty or while it drains.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_phys  <= VA_W'({frame, look_offset});
            r_frame <= frame;
            r_hit   <= hit;
            r_fault <= fault;
            r_fetch <= fault ? look_tag : '0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_phys;
    assign o_frame_number     = r_frame;
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
    assign o_fetch_page       = r_fetch;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Valid TLB entries always fill the row from the oldest end.
    `ASSERT_IMPL(a_tlb_packed, 1'b1, ((tlb_valid >> 1) & ~tlb_valid) == '0, "TLB valid gap")
    // A committed lookup always leaves a result in the output register.
    `ASSERT_NEXT(a_commit_out, commit, o_out_valid, "commit lost its result")
    // A TLB hit never also allocates a frame.
    `ASSERT_IMPL(a_hit_no_fault, o_out_valid, !(o_tlb_hit && o_page_fault), "hit with fault")
    // The page to fetch is zero unless the result is a fault.
    `ASSERT_IMPL(a_fetch_zero, o_out_valid && !o_page_fault, o_fetch_page == '0,
                 "fetch page without fault")

endmodule
